[rtl/palette_gradient_engine_macros.svh]
// Assertion macros for the palette gradient engine.
`ifndef PALETTE_GRADIENT_ENGINE_MACROS_SVH
`define PALETTE_GRADIENT_ENGINE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define PGE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define PGE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/pge_pkg.sv]
// Shared constants, types and helpers of the palette gradient engine.
`default_nettype none

package pge_pkg;

    localparam int ENTRIES   = 256;
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int IN_IDX_W  = 8;
    localparam int CH_W      = 8;
    localparam int NUM_CH    = 3;
    localparam int COLOR_W   = CH_W * NUM_CH;
    localparam int AMT_W     = 9;
    localparam int DATA_W    = 112;
    localparam int DIV_CNT_W = $clog2(CH_W + 1);

    localparam logic [AMT_W-1:0] AMT_MAX = AMT_W'(256);

    localparam logic [1:0] REQ_FILL  = 2'd0;
    localparam logic [1:0] REQ_GRAD  = 2'd1;
    localparam logic [1:0] REQ_BLEND = 2'd2;
    localparam logic [1:0] REQ_READ  = 2'd3;

    typedef logic [CH_W-1:0]  chan_t;
    typedef logic [IDX_W-1:0] idx_t;
    typedef chan_t [NUM_CH-1:0] chan_vec_t;
    typedef idx_t  [NUM_CH-1:0] idx_vec_t;

    localparam idx_t LAST_IDX = idx_t'(ENTRIES - 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_GRAD,
        ST_BLEND_RD,
        ST_BLEND,
        ST_READ_RD,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        ALU_PASS,
        ALU_GRAD,
        ALU_BLEND
    } alu_op_t;

    typedef struct packed {
        alu_op_t           op;
        logic [NUM_CH-1:0] neg;
    } alu_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // Indices past the palette saturate to the last entry.
    function automatic idx_t clamp_idx(input logic [IN_IDX_W-1:0] v);
        idx_t res;
        if ({1'b0, v} >= (IN_IDX_W + 1)'(ENTRIES))
            res = LAST_IDX;
        else
            res = idx_t'(v);
        return res;
    endfunction

endpackage

`default_nettype wire

[rtl/pge_div.sv]
// Three-lane restoring divider, one quotient bit per cycle.
`default_nettype none

module pge_div (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 start,
    input  pge_pkg::chan_vec_t  dividend,
    input  pge_pkg::idx_t       divisor,
    output pge_pkg::div_stat_t  stat,
    output pge_pkg::chan_vec_t  quot,
    output pge_pkg::idx_vec_t   rem
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [pge_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    pge_pkg::chan_vec_t            quo_reg, quo_next;
    pge_pkg::idx_vec_t             rem_reg, rem_next;
    logic [pge_pkg::IDX_W:0]       trial [pge_pkg::NUM_CH];
    logic [pge_pkg::IDX_W:0]       diff  [pge_pkg::NUM_CH];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        for (int k = 0; k < pge_pkg::NUM_CH; k++)
        begin
            trial[k] = {rem_reg[k], quo_reg[k][pge_pkg::CH_W-1]};
            diff[k]  = trial[k] - {1'b0, divisor};
        end
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = pge_pkg::DIV_CNT_W'(pge_pkg::CH_W);
            quo_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            for (int k = 0; k < pge_pkg::NUM_CH; k++)
            begin
                if (trial[k] >= {1'b0, divisor})
                begin
                    rem_next[k] = diff[k][pge_pkg::IDX_W-1:0];
                    quo_next[k] = {quo_reg[k][pge_pkg::CH_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next[k] = trial[k][pge_pkg::IDX_W-1:0];
                    quo_next[k] = {quo_reg[k][pge_pkg::CH_W-2:0], 1'b0};
                end
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == pge_pkg::DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = quo_reg;
    assign rem       = rem_reg;

endmodule

`default_nettype wire

[rtl/pge_alu.sv]
// Per-entry color arithmetic: pass-through, gradient step and blend.
`default_nettype none

module pge_alu (
    input  pge_pkg::alu_ctrl_t        ctrl,
    input  pge_pkg::chan_vec_t        base,
    input  pge_pkg::chan_vec_t        step_q,
    input  pge_pkg::chan_vec_t        cur,
    input  wire [pge_pkg::AMT_W-1:0]  amount,
    output pge_pkg::chan_vec_t        result
);

    logic signed [pge_pkg::CH_W:0]             diff [pge_pkg::NUM_CH];
    logic signed [pge_pkg::CH_W+pge_pkg::AMT_W+1:0] prod [pge_pkg::NUM_CH];
    logic signed [pge_pkg::AMT_W:0]            amt_s;

    always_comb
    begin
        amt_s = $signed({1'b0, amount});
        for (int k = 0; k < pge_pkg::NUM_CH; k++)
        begin
            // base holds the target color during a blend
            diff[k] = $signed({1'b0, base[k]}) - $signed({1'b0, cur[k]});
            prod[k] = diff[k] * amt_s;
            case (ctrl.op)
                pge_pkg::ALU_GRAD:
                    result[k] = ctrl.neg[k] ? base[k] - step_q[k] : base[k] + step_q[k];
                pge_pkg::ALU_BLEND:
                    // arithmetic shift gives the floor of the product with the Q1.8 amount
                    result[k] = cur[k] + prod[k][pge_pkg::CH_W+7:8];
                default:
                    result[k] = base[k];
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/palette_gradient_engine.sv]
// Top level of the palette gradient engine: sequencer, palette memory, result register.
`default_nettype none
`include "palette_gradient_engine_macros.svh"

// A 256-entry palette of 24-bit colors (red bits 7:0, green 15:8, blue 23:16),
// all black after reset. Each input transaction carries a request kind on
// s_tuser and returns exactly one output transaction. Fill writes the fill
// color to every entry; gradient writes a linear ramp over an index range
// (reversed indices are swapped, equal indices write one entry); blend moves
// every entry toward a target color by a Q1.8 amount (values above 256 act as
// 256); read returns one entry with m_tuser set, the others return zero with
// m_tuser clear. Indices past the palette saturate to the last entry.
// The block handles one request at a time; s_tready is high only between
// requests, and a finished result waits in the output register so the next
// request may be taken while it is still pending. Fill, blend and gradient
// writes are paced by the single write port of the palette memory, one
// entry per cycle; a gradient over more than one entry first runs one
// divider pass that yields per-channel slope and remainder, then writes
// one entry per cycle by accumulation.
module palette_gradient_engine (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          s_tvalid,
    output logic                         s_tready,
    // [7:0] first_index, [15:8] last_index, [39:16] first_color,
    // [63:40] last_color, [87:64] target_color, [96:88] blend_amount,
    // [104:97] read_index, [111:105] zero
    input  wire [pge_pkg::DATA_W-1:0]    s_tdata,
    // [1:0] req_type
    input  wire [1:0]                    s_tuser,
    output logic                         m_tvalid,
    input  wire                          m_tready,
    // [23:0] read_color
    output logic [pge_pkg::COLOR_W-1:0]  m_tdata,
    // [0] is_read_reply
    output logic [0:0]                   m_tuser
);

    // input fields
    logic [pge_pkg::IN_IDX_W-1:0] in_first_index, in_last_index, in_read_index;
    pge_pkg::chan_vec_t           in_first_color, in_last_color, in_target_color;
    logic [pge_pkg::AMT_W-1:0]    in_blend_amount;

    assign in_first_index  = s_tdata[7:0];
    assign in_last_index   = s_tdata[15:8];
    assign in_first_color  = s_tdata[39:16];
    assign in_last_color   = s_tdata[63:40];
    assign in_target_color = s_tdata[87:64];
    assign in_blend_amount = s_tdata[96:88];
    assign in_read_index   = s_tdata[104:97];

    // sequencer state and request context
    pge_pkg::state_t           state_reg, state_next;
    logic [1:0]                kind_reg, kind_next;
    pge_pkg::idx_t             lo_reg, lo_next;
    pge_pkg::idx_t             hi_reg, hi_next;
    pge_pkg::idx_t             idx_reg, idx_next;
    pge_pkg::chan_vec_t        color_a_reg, color_a_next;
    pge_pkg::chan_vec_t        color_b_reg, color_b_next;
    logic [pge_pkg::AMT_W-1:0] amt_reg, amt_next;
    pge_pkg::chan_vec_t        q_reg, q_next;
    pge_pkg::idx_vec_t         r_reg, r_next;

    // output register
    logic                      m_valid_reg, m_valid_next;
    pge_pkg::chan_vec_t        m_color_reg, m_color_next;
    logic                      m_read_reg, m_read_next;

    // control
    logic                      accept;
    logic                      wr_en, rd_en, div_start, out_load;
    pge_pkg::idx_t             wr_addr, rd_addr;
    pge_pkg::alu_ctrl_t        alu_ctrl;

    // capture-time helpers
    pge_pkg::idx_t             f_idx, l_idx;
    logic                      swap;

    // gradient helpers
    pge_pkg::idx_t             span;
    pge_pkg::chan_vec_t        div_dividend;
    pge_pkg::div_stat_t        div_stat;
    pge_pkg::chan_vec_t        div_quot;
    pge_pkg::idx_vec_t         div_rem;
    logic [pge_pkg::NUM_CH-1:0] neg;
    logic [pge_pkg::IDX_W:0]   r_sum [pge_pkg::NUM_CH];
    logic [pge_pkg::IDX_W:0]   r_wrap [pge_pkg::NUM_CH];

    // palette memory with per-entry valid bits (unwritten entries read black)
    logic [pge_pkg::COLOR_W-1:0] mem [pge_pkg::ENTRIES];
    logic [pge_pkg::ENTRIES-1:0] vld_reg;
    pge_pkg::chan_vec_t          rd_data_reg;
    logic                        rd_vld_reg;
    pge_pkg::chan_vec_t          rd_color;
    pge_pkg::chan_vec_t          wr_data;

    assign accept   = s_tvalid && s_tready;
    assign rd_color = rd_vld_reg ? rd_data_reg : '0;

    assign f_idx = pge_pkg::clamp_idx(in_first_index);
    assign l_idx = pge_pkg::clamp_idx(in_last_index);
    assign swap  = f_idx > l_idx;
    assign span  = hi_reg - lo_reg;

    // slope magnitude per channel, sign kept apart
    always_comb
    begin
        for (int k = 0; k < pge_pkg::NUM_CH; k++)
        begin
            neg[k]          = color_b_reg[k] < color_a_reg[k];
            div_dividend[k] = neg[k] ? color_a_reg[k] - color_b_reg[k]
                                     : color_b_reg[k] - color_a_reg[k];
        end
    end

    pge_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (span),
        .stat     (div_stat),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    pge_alu u_alu (
        .ctrl   (alu_ctrl),
        .base   (color_a_reg),
        .step_q (q_reg),
        .cur    (rd_color),
        .amount (amt_reg),
        .result (wr_data)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pge_pkg::ST_IDLE:
                if (s_tvalid)
                begin
                    case (s_tuser)
                        pge_pkg::REQ_FILL:  state_next = pge_pkg::ST_FILL;
                        pge_pkg::REQ_GRAD:  state_next = (f_idx == l_idx) ? pge_pkg::ST_GRAD
                                                                          : pge_pkg::ST_DIV_START;
                        pge_pkg::REQ_BLEND: state_next = pge_pkg::ST_BLEND_RD;
                        default:            state_next = pge_pkg::ST_READ_RD;
                    endcase
                end
            pge_pkg::ST_FILL:
                if (idx_reg == pge_pkg::LAST_IDX)
                    state_next = pge_pkg::ST_DONE;
            pge_pkg::ST_DIV_START:
                state_next = pge_pkg::ST_DIV_WAIT;
            pge_pkg::ST_DIV_WAIT:
                if (div_stat.done)
                    state_next = pge_pkg::ST_GRAD;
            pge_pkg::ST_GRAD:
                if (idx_reg == hi_reg)
                    state_next = pge_pkg::ST_DONE;
            pge_pkg::ST_BLEND_RD:
                state_next = pge_pkg::ST_BLEND;
            pge_pkg::ST_BLEND:
                if (idx_reg == pge_pkg::LAST_IDX)
                    state_next = pge_pkg::ST_DONE;
            pge_pkg::ST_READ_RD:
                state_next = pge_pkg::ST_DONE;
            pge_pkg::ST_DONE:
                if (!m_valid_reg || m_tready)
                    state_next = pge_pkg::ST_IDLE;
            default:
                state_next = pge_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        s_tready     = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = idx_reg;
        rd_en        = 1'b0;
        rd_addr      = idx_reg;
        div_start    = 1'b0;
        out_load     = 1'b0;
        alu_ctrl.op  = pge_pkg::ALU_PASS;
        alu_ctrl.neg = neg;
        case (state_reg)
            pge_pkg::ST_IDLE:
                s_tready = 1'b1;
            pge_pkg::ST_FILL:
                wr_en = 1'b1;
            pge_pkg::ST_DIV_START:
                div_start = 1'b1;
            pge_pkg::ST_GRAD:
            begin
                wr_en       = 1'b1;
                alu_ctrl.op = pge_pkg::ALU_GRAD;
            end
            pge_pkg::ST_BLEND_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = '0;
            end
            pge_pkg::ST_BLEND:
            begin
                // write entry idx while fetching idx+1
                wr_en       = 1'b1;
                alu_ctrl.op = pge_pkg::ALU_BLEND;
                rd_en       = 1'b1;
                rd_addr     = idx_reg + 1'b1;
            end
            pge_pkg::ST_READ_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = lo_reg;
            end
            pge_pkg::ST_DONE:
                out_load = !m_valid_reg || m_tready;
            default:
                s_tready = 1'b0;
        endcase
    end

    // request context and accumulators
    always_comb
    begin
        kind_next    = kind_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        idx_next     = idx_reg;
        color_a_next = color_a_reg;
        color_b_next = color_b_reg;
        amt_next     = amt_reg;
        q_next       = q_reg;
        r_next       = r_reg;
        for (int k = 0; k < pge_pkg::NUM_CH; k++)
        begin
            r_sum[k]  = {1'b0, r_reg[k]} + {1'b0, div_rem[k]};
            r_wrap[k] = r_sum[k] - {1'b0, span};
        end

        if (accept)
        begin
            kind_next = s_tuser;
            hi_next   = swap ? f_idx : l_idx;
            lo_next   = (s_tuser == pge_pkg::REQ_READ) ? pge_pkg::clamp_idx(in_read_index)
                                                       : (swap ? l_idx : f_idx);
            idx_next  = (s_tuser == pge_pkg::REQ_GRAD) ? (swap ? l_idx : f_idx) : '0;
            if (s_tuser == pge_pkg::REQ_BLEND)
                color_a_next = in_target_color;
            else if (s_tuser == pge_pkg::REQ_GRAD && swap)
                color_a_next = in_last_color;
            else
                color_a_next = in_first_color;
            color_b_next = swap ? in_first_color : in_last_color;
            amt_next     = (in_blend_amount > pge_pkg::AMT_MAX) ? pge_pkg::AMT_MAX
                                                                : in_blend_amount;
            q_next       = '0;
            r_next       = '0;
        end
        else if (state_reg == pge_pkg::ST_GRAD)
        begin
            idx_next = idx_reg + 1'b1;
            // running i*|d| = q*n + r, one slope step per entry
            for (int k = 0; k < pge_pkg::NUM_CH; k++)
            begin
                if (r_sum[k] >= {1'b0, span})
                begin
                    r_next[k] = r_wrap[k][pge_pkg::IDX_W-1:0];
                    q_next[k] = q_reg[k] + div_quot[k] + pge_pkg::CH_W'(1);
                end
                else
                begin
                    r_next[k] = r_sum[k][pge_pkg::IDX_W-1:0];
                    q_next[k] = q_reg[k] + div_quot[k];
                end
            end
        end
        else if (state_reg == pge_pkg::ST_FILL || state_reg == pge_pkg::ST_BLEND)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    // result register
    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_color_next = m_color_reg;
        m_read_next  = m_read_reg;
        if (out_load)
        begin
            m_valid_next = 1'b1;
            m_read_next  = (kind_reg == pge_pkg::REQ_READ);
            m_color_next = (kind_reg == pge_pkg::REQ_READ) ? rd_color : '0;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= pge_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
            vld_reg     <= '0;
            rd_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (wr_en)
                vld_reg[wr_addr] <= 1'b1;
            if (rd_en)
                rd_vld_reg <= vld_reg[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        idx_reg     <= idx_next;
        color_a_reg <= color_a_next;
        color_b_reg <= color_b_next;
        amt_reg     <= amt_next;
        q_reg       <= q_next;
        r_reg       <= r_next;
        m_color_reg <= m_color_next;
        m_read_reg  <= m_read_next;
    end

    // palette memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_color_reg;
    assign m_tuser  = m_read_reg;

    // checks
    `PGE_ASSERT_NOW(a_no_accept_during_write, wr_en, !s_tready,
        "palette written while a new transaction may be accepted")
    `PGE_ASSERT_NOW(a_div_done_in_wait, div_stat.done, state_reg == pge_pkg::ST_DIV_WAIT,
        "divider finished outside its wait state")
    `PGE_ASSERT_NOW(a_grad_in_range, state_reg == pge_pkg::ST_GRAD,
        idx_reg >= lo_reg && idx_reg <= hi_reg,
        "gradient write outside its index range")
    `PGE_ASSERT_NOW(a_nonread_zero, m_tvalid && !m_tuser[0], m_tdata == '0,
        "non-read result carries a color")

endmodule

`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for the palette gradient engine: stream driver, predictor, monitor.
`timescale 1ns / 1ps

module tb_top;

    localparam int STALL_MAX    = 12;
    localparam int HOLD_CYCLES  = 1500;   // long output back-pressure stretch
    localparam int HOLD_AT      = 300;    // reply count that starts it
    localparam int IDLE_LIMIT   = 20000;  // cycles with no transaction on either side
    localparam int TAIL_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 1080;

    // One request as it travels on s_tdata / s_tuser.
    typedef struct {
        logic [1:0]                kind;
        logic [7:0]                first_index;
        logic [7:0]                last_index;
        logic [23:0]               first_color;
        logic [23:0]               last_color;
        logic [23:0]               target_color;
        logic [pge_pkg::AMT_W-1:0] blend_amount;
        logic [7:0]                read_index;
    } pal_req_t;

    typedef struct {
        logic [23:0] color;
        logic        is_read;
    } reply_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [pge_pkg::DATA_W-1:0]   s_tdata = '0;
    logic [1:0]                   s_tuser = pge_pkg::REQ_FILL;
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [pge_pkg::COLOR_W-1:0]  m_tdata;
    logic [0:0]                   m_tuser;

    pal_req_t pending_requests[$];
    reply_t   expected_replies[$];
    pal_req_t in_flight;
    logic [23:0] palette_model[pge_pkg::ENTRIES];

    int errors = 0;
    int requests_sent = 0;
    int replies_seen = 0;
    int total_requests = 0;
    int kind_count[4] = '{0, 0, 0, 0};
    int tx_gap = 0;
    int rx_stall = 0;
    int rx_hold = 0;
    int idle_cycles = 0;

    palette_gradient_engine dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Indices at or past the palette size land on the last entry.
    function automatic int sat_index(input logic [7:0] v);
        int res;
        res = (int'(v) >= pge_pkg::ENTRIES) ? pge_pkg::ENTRIES - 1 : int'(v);
        return res;
    endfunction

    // Applies one request to the palette copy and returns the reply it must produce.
    function automatic reply_t apply_request(input pal_req_t r);
        reply_t      rep;
        int          lo, hi, n, tmp, a, b, v, amt;
        logic [23:0] clo, chi, ctmp, acc;
        rep.color   = '0;
        rep.is_read = 1'b0;
        case (r.kind)
            pge_pkg::REQ_FILL:
            begin
                for (int e = 0; e < pge_pkg::ENTRIES; e++)
                    palette_model[e] = r.first_color;
            end
            pge_pkg::REQ_GRAD:
            begin
                lo  = sat_index(r.first_index);
                hi  = sat_index(r.last_index);
                clo = r.first_color;
                chi = r.last_color;
                if (lo == hi)
                    palette_model[lo] = clo;
                else
                begin
                    if (lo > hi)
                    begin
                        tmp = lo;   lo = hi;   hi = tmp;
                        ctmp = clo; clo = chi; chi = ctmp;
                    end
                    n = hi - lo;
                    for (int i = 0; i <= n; i++)
                    begin
                        for (int k = 0; k < pge_pkg::NUM_CH; k++)
                        begin
                            a = int'(clo[8*k +: 8]);
                            b = int'(chi[8*k +: 8]);
                            // signed division truncates toward zero, as required
                            v = a + (i * (b - a)) / n;
                            acc[8*k +: 8] = v[7:0];
                        end
                        palette_model[lo + i] = acc;
                    end
                end
            end
            pge_pkg::REQ_BLEND:
            begin
                amt = (r.blend_amount > pge_pkg::AMT_MAX) ? int'(pge_pkg::AMT_MAX)
                                                          : int'(r.blend_amount);
                for (int e = 0; e < pge_pkg::ENTRIES; e++)
                begin
                    for (int k = 0; k < pge_pkg::NUM_CH; k++)
                    begin
                        a = int'(palette_model[e][8*k +: 8]);
                        b = int'(r.target_color[8*k +: 8]);
                        // arithmetic shift of a signed product is a floor divide by 256
                        v = a + (((b - a) * amt) >>> 8);
                        acc[8*k +: 8] = v[7:0];
                    end
                    palette_model[e] = acc;
                end
            end
            default:
            begin
                rep.color   = palette_model[sat_index(r.read_index)];
                rep.is_read = 1'b1;
            end
        endcase
        return rep;
    endfunction

    function automatic pal_req_t make_request(input logic [1:0] kind,
                                              input logic [7:0] fi, input logic [7:0] li,
                                              input logic [23:0] fc, input logic [23:0] lc,
                                              input logic [23:0] tc,
                                              input logic [pge_pkg::AMT_W-1:0] amt,
                                              input logic [7:0] ri);
        pal_req_t r;
        r.kind = kind;           r.first_index = fi;  r.last_index = li;
        r.first_color = fc;      r.last_color = lc;   r.target_color = tc;
        r.blend_amount = amt;    r.read_index = ri;
        return r;
    endfunction

    // Appends one request to the stimulus queue.
    task automatic add_request(input pal_req_t r);
        pending_requests = {pending_requests, r};
    endtask

    // Random request: every field random, kind and ranges shaped so most
    // gradients are short and reads land often enough to observe the palette.
    function automatic pal_req_t random_request();
        pal_req_t r;
        int       pick, span;
        r = make_request(pge_pkg::REQ_READ, 8'($urandom), 8'($urandom), 24'($urandom),
                         24'($urandom), 24'($urandom), pge_pkg::AMT_W'($urandom),
                         8'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 40)
            r.kind = pge_pkg::REQ_READ;
        else if (pick < 70)
            r.kind = pge_pkg::REQ_GRAD;
        else if (pick < 85)
            r.kind = pge_pkg::REQ_BLEND;
        else
            r.kind = pge_pkg::REQ_FILL;
        if ($urandom_range(0, 9) < 6)
        begin
            span = $urandom_range(0, 32) - 16;
            span = int'(r.first_index) + span;
            span = (span < 0) ? 0 : ((span > 255) ? 255 : span);
            r.last_index = 8'(span);
        end
        // mostly in-range blend amounts, some above full scale
        if ($urandom_range(0, 9) < 7)
            r.blend_amount = pge_pkg::AMT_W'($urandom_range(0, 256));
        return r;
    endfunction

    // Stimulus and end of run
    initial
    begin
        // extremes, full ramp, reversed and single-entry ranges
        add_request(make_request(pge_pkg::REQ_FILL, '0, '0, 24'hFFFFFF, '0, '0, '0, '0));
        add_request(make_request(pge_pkg::REQ_READ, '0, '0, '0, '0, '0, '0, 8'd0));
        add_request(make_request(pge_pkg::REQ_READ, '0, '0, '0, '0, '0, '0, 8'd255));
        add_request(make_request(pge_pkg::REQ_GRAD, 8'd0, 8'd255, 24'h000000,
                                 24'hFFFFFF, '0, '0, '0));
        add_request(make_request(pge_pkg::REQ_READ, '0, '0, '0, '0, '0, '0, 8'd128));
        add_request(make_request(pge_pkg::REQ_READ, '0, '0, '0, '0, '0, '0, 8'd255));
        add_request(make_request(pge_pkg::REQ_GRAD, 8'd200, 8'd10, 24'h123456,
                                 24'hFEDCBA, '0, '0, '0));
        add_request(make_request(pge_pkg::REQ_READ, '0, '0, '0, '0, '0, '0, 8'd10));
        add_request(make_request(pge_pkg::REQ_READ, '0, '0, '0, '0, '0, '0, 8'd100));
        add_request(make_request(pge_pkg::REQ_READ, '0, '0, '0, '0, '0, '0, 8'd200));
        add_request(make_request(pge_pkg::REQ_GRAD, 8'd77, 8'd77, 24'hA5C3E1,
                                 24'h000000, '0, '0, '0));
        add_request(make_request(pge_pkg::REQ_READ, '0, '0, '0, '0, '0, '0, 8'd77));
        // falling channels exercise truncation toward zero on negative slopes
        add_request(make_request(pge_pkg::REQ_GRAD, 8'd5, 8'd12, 24'h00FF80,
                                 24'hFF0041, '0, '0, '0));
        add_request(make_request(pge_pkg::REQ_READ, '0, '0, '0, '0, '0, '0, 8'd8));
        add_request(make_request(pge_pkg::REQ_GRAD, 8'd254, 8'd255, 24'hFFFFFF,
                                 24'h000000, '0, '0, '0));
        add_request(make_request(pge_pkg::REQ_READ, '0, '0, '0, '0, '0, '0, 8'd254));
        // blend: zero, partial, just below full scale, past full scale
        add_request(make_request(pge_pkg::REQ_BLEND, '0, '0, '0, '0, 24'h00FF00,
                                 pge_pkg::AMT_W'(0), '0));
        add_request(make_request(pge_pkg::REQ_BLEND, '0, '0, '0, '0, 24'hFF00FF,
                                 pge_pkg::AMT_W'(100), '0));
        add_request(make_request(pge_pkg::REQ_READ, '0, '0, '0, '0, '0, '0, 8'd8));
        add_request(make_request(pge_pkg::REQ_BLEND, '0, '0, '0, '0, 24'h000000,
                                 pge_pkg::AMT_W'(255), '0));
        add_request(make_request(pge_pkg::REQ_READ, '0, '0, '0, '0, '0, '0, 8'd200));
        add_request(make_request(pge_pkg::REQ_BLEND, '0, '0, '0, '0, 24'h3C5A78,
                                 pge_pkg::AMT_W'(511), '0));
        add_request(make_request(pge_pkg::REQ_READ, '0, '0, '0, '0, '0, '0, 8'd33));
        add_request(make_request(pge_pkg::REQ_FILL, '0, '0, 24'h000000, '0, '0, '0, '0));
        add_request(make_request(pge_pkg::REQ_READ, '0, '0, '0, '0, '0, '0, 8'd255));
        for (int i = 0; i < RANDOM_ITEMS; i++)
            add_request(random_request());
        total_requests = pending_requests.size();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // every request returns exactly one reply
        while (replies_seen < total_requests)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Run covered %0d requests (fill %0d, gradient %0d, blend %0d, read %0d),",
                 requests_sent, kind_count[pge_pkg::REQ_FILL], kind_count[pge_pkg::REQ_GRAD],
                 kind_count[pge_pkg::REQ_BLEND], kind_count[pge_pkg::REQ_READ]);
        $display("%0d replies checked, including one long output back-pressure stretch.",
                 replies_seen);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Driver: presents queued requests, random gap before each, updates the
    // palette copy on every accepted transaction.
    always @(posedge clk or negedge rst_n)
    begin : driver
        reply_t rep_new;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= pge_pkg::REQ_FILL;
            tx_gap = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                rep_new = apply_request(in_flight);
                expected_replies = {expected_replies, rep_new};
                kind_count[in_flight.kind]++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_requests.size() > 0)
                begin
                    in_flight = pending_requests.pop_front();
                    s_tdata  <= {7'b0, in_flight.read_index, in_flight.blend_amount,
                                 in_flight.target_color, in_flight.last_color,
                                 in_flight.first_color, in_flight.last_index,
                                 in_flight.first_index};
                    s_tuser  <= in_flight.kind;
                    s_tvalid <= 1'b1;
                    requests_sent++;
                    // runs of back-to-back transactions between random gaps
                    tx_gap = ((requests_sent % 90) < 20) ? 0 : $urandom_range(0, STALL_MAX);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: random ready stalls, one long hold, field-by-field compare.
    always @(posedge clk or negedge rst_n)
    begin : monitor
        reply_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_stall = 0;
            rx_hold  = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                replies_seen++;
                if (expected_replies.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected reply color=%06h read=%0b",
                             $time, m_tdata, m_tuser[0]);
                end
                else
                begin
                    want = expected_replies.pop_front();
                    if (m_tdata !== want.color)
                    begin
                        errors++;
                        $display("%0t: read_color expected %06h actual %06h",
                                 $time, want.color, m_tdata);
                    end
                    if (m_tuser[0] !== want.is_read)
                    begin
                        errors++;
                        $display("%0t: is_read_reply expected %0b actual %0b",
                                 $time, want.is_read, m_tuser[0]);
                    end
                end
                rx_stall = ((replies_seen % 70) < 15) ? 0 : $urandom_range(0, STALL_MAX);
                // the engine fills its output register and stalls its input
                if (replies_seen == HOLD_AT)
                    rx_hold = HOLD_CYCLES;
            end
            if (rx_hold > 0)
            begin
                rx_hold--;
                m_tready <= 1'b0;
            end
            else if (rx_stall > 0)
            begin
                rx_stall--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Watchdog: ends the run when neither side moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: timeout, no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

endmodule
